[hw/rtl/rss_pkg.sv]
// Shared types and constants for the running set statistics block.
`timescale 1ns / 1ps

package rss_pkg;

  localparam int MAX_COUNT = 65536;
  localparam int FRAC_BITS = 8;

  localparam int SAMPLE_W = 32;
  localparam int SUM_W    = 48;
  localparam int MEAN_W   = 40;
  localparam int OUT_CNT_W = 17;

  localparam int CNT_W  = $clog2(MAX_COUNT + 1);
  localparam int DVD_W  = SUM_W + FRAC_BITS;
  localparam int STEP_W = $clog2(DVD_W);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       set_end;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0]       item_count;
    logic signed [SUM_W-1:0]    total;
    logic signed [MEAN_W-1:0]   mean_q8;
    logic signed [SAMPLE_W-1:0] smallest;
    logic signed [SAMPLE_W-1:0] largest;
    logic [SAMPLE_W-1:0]        spread;
    logic [OUT_CNT_W-1:0]       even_total;
    logic [OUT_CNT_W-1:0]       odd_total;
    logic                       count_overflow;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic acc;
    logic close;
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

[hw/rtl/rss_ctrl.sv]
// Sequencer for accumulation, division and result hand-off.
`timescale 1ns / 1ps

module rss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rss_pkg::status_t status,
  output rss_pkg::cmd_t    cmd
);
  import rss_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_last) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: state_next = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.acc   = in_valid && !in_last;
        cmd.close = in_valid && in_last;
      end
      ST_LOAD: begin
        in_ready = !in_last;
        cmd.acc  = in_valid && !in_last;
        cmd.load = 1'b1;
      end
      ST_DIV: begin
        in_ready = !in_last;
        cmd.acc  = in_valid && !in_last;
        cmd.step = 1'b1;
      end
      ST_FIN: begin
        in_ready   = !in_last;
        cmd.acc    = in_valid && !in_last;
        cmd.finish = 1'b1;
      end
      ST_OUT: begin
        in_ready  = !in_last;
        cmd.acc   = in_valid && !in_last;
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/rss_datapath.sv]
// Accumulators, result snapshot and bit-serial divider for the set mean.
`timescale 1ns / 1ps

module rss_datapath (
  input  logic               clk,
  input  logic               rst,
  input  rss_pkg::in_beat_t  in_data,
  input  rss_pkg::cmd_t      cmd,
  output rss_pkg::status_t   status,
  output rss_pkg::out_beat_t out_data
);
  import rss_pkg::*;

  localparam logic [DVD_W-1:0] MEAN_NEG_LIM = DVD_W'(1) << (MEAN_W - 1);
  localparam logic [DVD_W-1:0] MEAN_POS_LIM = MEAN_NEG_LIM - DVD_W'(1);

  logic [CNT_W-1:0]          seen_count;
  logic [SUM_W-1:0]          running_sum;
  logic signed [SAMPLE_W-1:0] running_min;
  logic signed [SAMPLE_W-1:0] running_max;
  logic [CNT_W-1:0]          even_seen;
  logic [CNT_W-1:0]          odd_seen;
  logic                      set_open;
  logic                      overflowed;

  logic [CNT_W-1:0]          seen_count_next;
  logic [SUM_W-1:0]          running_sum_next;
  logic signed [SAMPLE_W-1:0] running_min_next;
  logic signed [SAMPLE_W-1:0] running_max_next;
  logic [CNT_W-1:0]          even_seen_next;
  logic [CNT_W-1:0]          odd_seen_next;
  logic                      overflowed_next;
  logic                      full;

  logic [CNT_W-1:0]          snap_count;
  logic [SUM_W-1:0]          snap_sum;
  logic signed [SAMPLE_W-1:0] snap_min;
  logic signed [SAMPLE_W-1:0] snap_max;
  logic [CNT_W-1:0]          snap_even;
  logic [CNT_W-1:0]          snap_odd;
  logic                      snap_ovf;
  logic [SAMPLE_W-1:0]       spread;
  logic signed [MEAN_W-1:0]  mean;

  logic [DVD_W-1:0]          dvd;
  logic [CNT_W-1:0]          rem;
  logic [STEP_W-1:0]         step_cnt;
  logic                      neg;
  logic [SUM_W-1:0]          mag;
  logic [CNT_W:0]            rem_sh;
  logic [CNT_W:0]            rem_diff;
  logic                      ge;
  logic [DVD_W-1:0]          q_sat;

  always_comb begin
    full             = (seen_count >= CNT_W'(MAX_COUNT));
    seen_count_next  = seen_count;
    running_sum_next = running_sum;
    running_min_next = running_min;
    running_max_next = running_max;
    even_seen_next   = even_seen;
    odd_seen_next    = odd_seen;
    overflowed_next  = overflowed;
    if (full) begin
      overflowed_next = 1'b1;
    end else begin
      seen_count_next  = seen_count + CNT_W'(1);
      running_sum_next = running_sum
                         + {{(SUM_W - SAMPLE_W){in_data.sample[SAMPLE_W-1]}}, in_data.sample};
      if (!set_open || (in_data.sample < running_min)) begin
        running_min_next = in_data.sample;
      end
      if (!set_open || (in_data.sample > running_max)) begin
        running_max_next = in_data.sample;
      end
      if (in_data.sample[0]) begin
        odd_seen_next = odd_seen + CNT_W'(1);
      end else begin
        even_seen_next = even_seen + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.close) begin
      seen_count  <= '0;
      running_sum <= '0;
      running_min <= '0;
      running_max <= '0;
      even_seen   <= '0;
      odd_seen    <= '0;
      set_open    <= 1'b0;
      overflowed  <= 1'b0;
    end else if (cmd.acc) begin
      seen_count  <= seen_count_next;
      running_sum <= running_sum_next;
      running_min <= running_min_next;
      running_max <= running_max_next;
      even_seen   <= even_seen_next;
      odd_seen    <= odd_seen_next;
      set_open    <= set_open || !full;
      overflowed  <= overflowed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      snap_count <= seen_count_next;
      snap_sum   <= running_sum_next;
      snap_min   <= running_min_next;
      snap_max   <= running_max_next;
      snap_even  <= even_seen_next;
      snap_odd   <= odd_seen_next;
      snap_ovf   <= overflowed_next;
    end
  end

  // Restoring division of |sum| << FRAC_BITS by the count, one quotient bit per step.
  always_comb begin
    mag      = snap_sum[SUM_W-1] ? (SUM_W'(0) - snap_sum) : snap_sum;
    rem_sh   = {rem, dvd[DVD_W-1]};
    rem_diff = rem_sh - {1'b0, snap_count};
    ge       = (rem_sh >= {1'b0, snap_count});
    if (neg) begin
      q_sat = (dvd > MEAN_NEG_LIM) ? MEAN_NEG_LIM : dvd;
    end else begin
      q_sat = (dvd > MEAN_POS_LIM) ? MEAN_POS_LIM : dvd;
    end
  end

  assign status.div_done = (step_cnt == STEP_W'(DVD_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd      <= DVD_W'(mag) << FRAC_BITS;
      rem      <= '0;
      step_cnt <= '0;
      neg      <= snap_sum[SUM_W-1];
    end else if (cmd.step) begin
      dvd      <= {dvd[DVD_W-2:0], ge};
      rem      <= ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      step_cnt <= step_cnt + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      mean   <= neg ? MEAN_W'(DVD_W'(0) - q_sat) : MEAN_W'(q_sat);
      spread <= snap_max - snap_min;
    end
  end

  always_comb begin
    out_data.item_count     = OUT_CNT_W'(snap_count);
    out_data.total          = snap_sum;
    out_data.mean_q8        = mean;
    out_data.smallest       = snap_min;
    out_data.largest        = snap_max;
    out_data.spread         = spread;
    out_data.even_total     = OUT_CNT_W'(snap_even);
    out_data.odd_total      = OUT_CNT_W'(snap_odd);
    out_data.count_overflow = snap_ovf;
  end

endmodule

[hw/rtl/running_set_statistics_top.sv]
// Top level of the running set statistics block.
`timescale 1ns / 1ps
//
// Input channel in_valid/in_ready/in_data carries one sample per beat; a beat
// with set_end high closes the set. Output channel out_valid/out_ready/out_data
// carries one result beat per set: count, sum, mean (Q8), min, max, spread,
// even and odd counts and the count overflow flag.
// Samples that do not close a set are taken one per cycle at all times.
// The closing beat snapshots the statistics and clears the accumulators, so
// the next set starts accumulating at once. The mean comes from a restoring
// divider giving one quotient bit per cycle: out_valid rises in ST_OUT, which
// follows ST_LOAD, ST_DIV and ST_FIN after the edge that takes the closing beat.
// A further closing beat waits until the pending result has been taken and
// enters in the cycle after that, so samples flow at one per cycle except where
// a closing beat must wait, and a stream of short sets is limited by the division
// and result hand-off plus the receiver's stall.
// While out_ready is low the result holds in its registers and non-closing
// samples keep flowing. Synchronous reset clears all accumulators and
// returns the sequencer to idle with no result pending.

module running_set_statistics_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rss_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rss_pkg::out_beat_t out_data
);
  import rss_pkg::*;

  cmd_t    cmd;
  status_t status;

  rss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.set_end),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rss_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

[test/running_set_statistics_checker.sv]
// Checker for running set statistics: predicts per-set results from input beats and compares.
`timescale 1ns / 1ps

module running_set_statistics_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  rss_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  rss_pkg::out_beat_t out_data,
  output int                 fails,
  output int                 waiting
);
  import rss_pkg::*;

  int unsigned             seen_cnt;
  int unsigned             even_cnt;
  int unsigned             odd_cnt;
  logic [SUM_W-1:0]        sum_acc;
  logic signed [SAMPLE_W-1:0] min_acc;
  logic signed [SAMPLE_W-1:0] max_acc;
  logic                    set_active;
  logic                    bound_hit;

  out_beat_t               stats_pending[$];
  int                      fail_count = 0;
  int                      pend_count = 0;

  assign fails   = fail_count;
  assign waiting = pend_count;

  function automatic logic [MEAN_W-1:0] mean_fixed(logic [SUM_W-1:0] sum_bits,
                                                   int unsigned cnt);
    logic signed [63:0] wide;
    logic [63:0]        mag;
    logic [63:0]        divisor;
    logic [63:0]        q;
    logic [63:0]        neg_lim;
    logic [63:0]        pos_lim;
    wide    = {{(64-SUM_W){sum_bits[SUM_W-1]}}, sum_bits};
    mag     = wide[63] ? -wide : wide;
    divisor = cnt;
    q       = (mag << FRAC_BITS) / divisor;
    neg_lim = 64'd1 << (MEAN_W - 1);
    pos_lim = neg_lim - 64'd1;
    if (wide[63]) begin
      if (q > neg_lim) q = neg_lim;
      q = 64'd0 - q;
    end else if (q > pos_lim) begin
      q = pos_lim;
    end
    return q[MEAN_W-1:0];
  endfunction

  task automatic clear_stats();
    seen_cnt   = 0;
    even_cnt   = 0;
    odd_cnt    = 0;
    sum_acc    = '0;
    min_acc    = '0;
    max_acc    = '0;
    set_active = 1'b0;
    bound_hit  = 1'b0;
  endtask

  task automatic absorb_sample(in_beat_t b);
    out_beat_t r;
    logic signed [SAMPLE_W-1:0] v;
    v = $signed(b.sample);
    if (seen_cnt >= MAX_COUNT) begin
      bound_hit = 1'b1;
    end else begin
      if (!set_active) begin
        min_acc    = v;
        max_acc    = v;
        set_active = 1'b1;
      end else begin
        if (v < min_acc) min_acc = v;
        if (v > max_acc) max_acc = v;
      end
      sum_acc = sum_acc + {{(SUM_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
      if (v[0]) odd_cnt++;
      else even_cnt++;
      seen_cnt++;
    end
    if (b.set_end) begin
      r.item_count     = seen_cnt[OUT_CNT_W-1:0];
      r.total          = sum_acc;
      r.mean_q8        = mean_fixed(sum_acc, seen_cnt);
      r.smallest       = min_acc;
      r.largest        = max_acc;
      r.spread         = max_acc - min_acc;
      r.even_total     = even_cnt[OUT_CNT_W-1:0];
      r.odd_total      = odd_cnt[OUT_CNT_W-1:0];
      r.count_overflow = bound_hit;
      stats_pending = {stats_pending, r};
      clear_stats();
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_stats(out_beat_t want, out_beat_t got);
    check_field("item_count", want.item_count, got.item_count);
    check_field("total", want.total, got.total);
    check_field("mean_q8", want.mean_q8, got.mean_q8);
    check_field("smallest", want.smallest, got.smallest);
    check_field("largest", want.largest, got.largest);
    check_field("spread", want.spread, got.spread);
    check_field("even_total", want.even_total, got.even_total);
    check_field("odd_total", want.odd_total, got.odd_total);
    check_field("count_overflow", want.count_overflow, got.count_overflow);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_stats();
      stats_pending.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (stats_pending.size() == 0) begin
          $display("%0t: result beat expected none actual %p", $time, out_data);
          fail_count++;
        end else begin
          compare_stats(stats_pending.pop_front(), out_data);
        end
      end
      if (in_valid && in_ready) absorb_sample(in_data);
    end
    pend_count = stats_pending.size();
  end

endmodule

[test/tb_running_set_statistics_top.sv]
// Testbench top for running set statistics: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_running_set_statistics_top;
  import rss_pkg::*;

  localparam int ITEMS       = 500;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG    = 4000;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 80;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  int        fails;
  int        waiting;
  int        idle_cycles = 0;
  int        rand_items = 0;
  logic      tx_quiet = 1'b0;
  logic      rx_quiet = 1'b0;
  logic      hold_req = 1'b0;
  logic      hold_done = 1'b0;

  running_set_statistics_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  running_set_statistics_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fails     (fails),
    .waiting   (waiting)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFFFFFF - $urandom_range(0, 3);
      1:       return 32'sh80000000 + $urandom_range(0, 3);
      2, 3:    return $urandom_range(0, 16) - 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic int rand_set_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 4);
    if (r < 80) return $urandom_range(5, 16);
    if (r < 95) return $urandom_range(17, 64);
    return $urandom_range(65, 120);
  endfunction

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] v, input logic last);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{sample: v, set_end: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap_left;
    int tick;
    gap_left = 0;
    tick     = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (tick % 256 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        if (gap_left > 0) begin
          out_ready <= 1'b0;
          gap_left--;
        end else begin
          out_ready <= 1'b1;
          if (!rx_quiet && $urandom_range(0, 3) == 0) gap_left = pick_gap();
        end
        tick++;
        @(posedge clk);
      end
    end
  end

  initial begin
    int len;
    int drain;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_sample(32'sh7FFFFFFF, 1'b1);
    push_sample(32'sh80000000, 1'b1);
    push_sample(0, 1'b1);
    push_sample(32'sh7FFFFFFF, 1'b0);
    push_sample(32'sh80000000, 1'b1);
    push_sample(32'sh80000000, 1'b0);
    push_sample(32'sh7FFFFFFF, 1'b1);
    push_sample(-1, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(0, 1'b1);
    push_sample(1, 1'b0);
    push_sample(1, 1'b0);
    push_sample(0, 1'b1);
    push_sample(0, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(1, 1'b0);
    push_sample(2, 1'b0);
    push_sample(-2, 1'b1);
    push_sample(-3, 1'b0);
    push_sample(5, 1'b0);
    push_sample(-7, 1'b0);
    push_sample(9, 1'b1);
    push_sample(32'sh7FFFFFFF, 1'b0);
    push_sample(32'sh7FFFFFFF, 1'b0);
    push_sample(32'sh7FFFFFFF, 1'b1);

    while (rand_items < ITEMS) begin
      tx_quiet = ($urandom_range(0, 5) == 0);
      len = rand_set_len();
      for (int i = 0; i < len; i++) begin
        if (rand_items >= HOLD_AT) hold_req = 1'b1;
        push_sample(rand_sample(), i == len - 1);
        rand_items++;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    drain = 0;
    while (waiting != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    if (waiting != 0) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (fails == 0 && waiting == 0) begin
        $display("RESULT: OK");
      end else begin
        $display("RESULT: ERROR");
      end
      $finish;
    end
  end

endmodule

[sim.f]
hw/rtl/rss_pkg.sv
hw/rtl/rss_ctrl.sv
hw/rtl/rss_datapath.sv
hw/rtl/running_set_statistics_top.sv
test/running_set_statistics_checker.sv
test/tb_running_set_statistics_top.sv
